// ===== hw/rtl/tgfw_pkg.sv =====
// shared types, constants and font table for the text glyph framebuffer writer
package tgfw_pkg;

    localparam int OP_W    = 2;
    localparam int CODE_W  = 8;
    localparam int OX_W    = 7;
    localparam int OY_W    = 6;
    localparam int RADDR_W = 10;
    // cursor registers: column reaches the frame width (up to 256) or origin plus a glyph
    localparam int COL_W   = 9;
    // row reaches the frame height (up to 128)
    localparam int ROW_W   = 8;
    localparam int GIDX_W  = 6;
    localparam int GLYPH_COUNT = 59;
    localparam logic [CODE_W-1:0] FIRST_CODE   = 8'd32;
    localparam logic [CODE_W-1:0] LAST_FONT    = 8'd90;
    localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'd10;
    localparam int GLYPH_SIZE = 8;

    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_DRAW  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;
    // unused code, no effect
    localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [CODE_W-1:0]  char_code;
        logic               first_of_text;
        logic [OX_W-1:0]    origin_x;
        logic [OY_W-1:0]    origin_y;
        logic [RADDR_W-1:0] read_address;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       text_stopped;
    } result_t;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_DRAW  = 2'd2,
        CMD_READ  = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic               stopped;
        logic [GIDX_W-1:0]  gidx;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic [RADDR_W-1:0] addr;
    } cmd_t;

    // queue status seen by the top level
    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    // font rows, row 0 first, bit 0 is the leftmost pixel
    localparam logic [7:0] FONT_ROM [GLYPH_COUNT][8] = '{
        '{'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00}, '{'h18,'h3C,'h3C,'h18,'h18,'h00,'h18,'h00},
        '{'h36,'h36,'h00,'h00,'h00,'h00,'h00,'h00}, '{'h36,'h36,'h7F,'h36,'h7F,'h36,'h36,'h00},
        '{'h0C,'h3E,'h03,'h1E,'h30,'h1F,'h0C,'h00}, '{'h00,'h63,'h33,'h18,'h0C,'h66,'h63,'h00},
        '{'h1C,'h36,'h1C,'h6E,'h3B,'h33,'h6E,'h00}, '{'h06,'h06,'h03,'h00,'h00,'h00,'h00,'h00},
        '{'h18,'h0C,'h06,'h06,'h06,'h0C,'h18,'h00}, '{'h06,'h0C,'h18,'h18,'h18,'h0C,'h06,'h00},
        '{'h00,'h66,'h3C,'hFF,'h3C,'h66,'h00,'h00}, '{'h00,'h0C,'h0C,'h3F,'h0C,'h0C,'h00,'h00},
        '{'h00,'h00,'h00,'h00,'h00,'h0C,'h06,'h00}, '{'h00,'h00,'h00,'h3F,'h00,'h00,'h00,'h00},
        '{'h00,'h00,'h00,'h00,'h00,'h0C,'h0C,'h00}, '{'h60,'h30,'h18,'h0C,'h06,'h03,'h01,'h00},
        '{'h3E,'h63,'h73,'h7B,'h6F,'h67,'h3E,'h00}, '{'h0C,'h0E,'h0C,'h0C,'h0C,'h0C,'h3F,'h00},
        '{'h1E,'h33,'h30,'h1C,'h06,'h33,'h3F,'h00}, '{'h1E,'h33,'h30,'h1C,'h30,'h33,'h1E,'h00},
        '{'h38,'h3C,'h36,'h33,'h7F,'h30,'h78,'h00}, '{'h3F,'h03,'h1F,'h30,'h30,'h33,'h1E,'h00},
        '{'h1C,'h06,'h03,'h1F,'h33,'h33,'h1E,'h00}, '{'h3F,'h33,'h30,'h18,'h0C,'h0C,'h0C,'h00},
        '{'h1E,'h33,'h33,'h1E,'h33,'h33,'h1E,'h00}, '{'h1E,'h33,'h33,'h3E,'h30,'h18,'h0E,'h00},
        '{'h00,'h0C,'h0C,'h00,'h00,'h0C,'h0C,'h00}, '{'h00,'h0C,'h0C,'h00,'h00,'h0C,'h06,'h00},
        '{'h18,'h0C,'h06,'h03,'h06,'h0C,'h18,'h00}, '{'h00,'h00,'h3F,'h00,'h00,'h3F,'h00,'h00},
        '{'h06,'h0C,'h18,'h30,'h18,'h0C,'h06,'h00}, '{'h1E,'h33,'h30,'h18,'h0C,'h00,'h0C,'h00},
        '{'h3E,'h63,'h7B,'h7B,'h7B,'h03,'h1E,'h00}, '{'h0C,'h1E,'h33,'h33,'h3F,'h33,'h33,'h00},
        '{'h3F,'h66,'h66,'h3E,'h66,'h66,'h3F,'h00}, '{'h3C,'h66,'h03,'h03,'h03,'h66,'h3C,'h00},
        '{'h1F,'h36,'h66,'h66,'h66,'h36,'h1F,'h00}, '{'h7F,'h46,'h16,'h1E,'h16,'h46,'h7F,'h00},
        '{'h7F,'h46,'h16,'h1E,'h16,'h06,'h0F,'h00}, '{'h3C,'h66,'h03,'h03,'h73,'h66,'h7C,'h00},
        '{'h33,'h33,'h33,'h3F,'h33,'h33,'h33,'h00}, '{'h1E,'h0C,'h0C,'h0C,'h0C,'h0C,'h1E,'h00},
        '{'h78,'h30,'h30,'h30,'h33,'h33,'h1E,'h00}, '{'h67,'h66,'h36,'h1E,'h36,'h66,'h67,'h00},
        '{'h0F,'h06,'h06,'h06,'h46,'h66,'h7F,'h00}, '{'h63,'h77,'h7F,'h7F,'h6B,'h63,'h63,'h00},
        '{'h63,'h67,'h6F,'h7B,'h73,'h63,'h63,'h00}, '{'h1C,'h36,'h63,'h63,'h63,'h36,'h1C,'h00},
        '{'h3F,'h66,'h66,'h3E,'h06,'h06,'h0F,'h00}, '{'h1E,'h33,'h33,'h33,'h3B,'h1E,'h38,'h00},
        '{'h3F,'h66,'h66,'h3E,'h36,'h66,'h67,'h00}, '{'h1E,'h33,'h07,'h0E,'h38,'h33,'h1E,'h00},
        '{'h3F,'h2D,'h0C,'h0C,'h0C,'h0C,'h1E,'h00}, '{'h33,'h33,'h33,'h33,'h33,'h33,'h3F,'h00},
        '{'h33,'h33,'h33,'h33,'h33,'h1E,'h0C,'h00}, '{'h63,'h63,'h63,'h6B,'h7F,'h77,'h63,'h00},
        '{'h63,'h63,'h36,'h1C,'h1C,'h36,'h63,'h00}, '{'h33,'h33,'h33,'h1E,'h0C,'h0C,'h1E,'h00},
        '{'h7F,'h63,'h31,'h18,'h4C,'h66,'h7F,'h00}
    };

endpackage

// ===== hw/rtl/text_glyph_framebuffer_writer_core.sv =====
// top level of the 8x8 text glyph framebuffer writer
//
// command channel: an item transfers on a rising edge with start high and busy low.
//   operation selects clear frame, draw character or read one frame byte.
// result channel: every item gives one result, shown for exactly one cycle with done
//   high; the receiver cannot stall, so results never back up.
// the front end keeps the text cursor and turns each item into a command; a two-entry
//   queue feeds the back end, which owns the frame store (one write and one read port).
// work per item once it reaches the back end:
//   draw of a font glyph: idle takes it, 16 read-modify-write steps (8 columns x 2 pages), then a finish state
//   read: a read state, then a result state; clear: writes all FRAME_WIDTH*ceil(FRAME_HEIGHT/8) bytes
//   other items (newline, blanks, dropped characters): result given straight from idle
// the frame store ports are what set this order of work; busy rises when the queue is full.
// reset: cursor and halt clear, and a clearing sweep zeroes all FRAME_WIDTH*ceil(FRAME_HEIGHT/8)
//   bytes of the frame store with busy high; no result is given for it.
module text_glyph_framebuffer_writer_core #(
    parameter int FRAME_WIDTH  = 128,
    parameter int FRAME_HEIGHT = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  tgfw_pkg::item_t   item,
    output logic              done,
    output tgfw_pkg::result_t result
);
    import tgfw_pkg::*;

    logic      accept;
    cmd_t      front_cmd, q_cmd;
    q_status_t q_status;
    logic      pop, init;

    // hold off transfers while the queue is full or the store is still being cleared
    assign busy   = q_status.full || init;
    assign accept = start && !busy;

    tgfw_front #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .cmd    (front_cmd)
    );

    tgfw_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (accept),
        .din    (front_cmd),
        .pop    (pop),
        .dout   (q_cmd),
        .status (q_status)
    );

    tgfw_back #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_status.empty),
        .cmd     (q_cmd),
        .pop     (pop),
        .init    (init),
        .done    (done),
        .result  (result)
    );

endmodule

// ===== hw/rtl/tgfw_front.sv =====
// front end: cursor tracking and command classification
module tgfw_front #(
    parameter int FRAME_WIDTH  = 128,
    parameter int FRAME_HEIGHT = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  tgfw_pkg::item_t item,
    output tgfw_pkg::cmd_t  cmd
);
    import tgfw_pkg::*;

    logic [COL_W-1:0] col_reg, col_next, ls_reg, ls_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             halt_reg, halt_next;

    logic [COL_W-1:0] col_e, ls_e, col_1;
    logic [ROW_W-1:0] row_e, row_1, row_nl;
    logic             halt_e;
    logic [ROW_W:0]   row_1_sum;
    logic [COL_W:0]   col_sum;
    logic             printable;

    // row down one glyph, saturating at the frame height
    function automatic logic [ROW_W-1:0] down(input logic [ROW_W-1:0] r);
        logic [ROW_W:0] s;
        s = {1'b0, r} + (ROW_W+1)'(GLYPH_SIZE);
        if (s > (ROW_W+1)'(FRAME_HEIGHT))
            down = ROW_W'(FRAME_HEIGHT);
        else
            down = s[ROW_W-1:0];
    endfunction

    always_comb
    begin
        col_e  = item.first_of_text ? COL_W'(item.origin_x) : col_reg;
        ls_e   = item.first_of_text ? COL_W'(item.origin_x) : ls_reg;
        row_e  = item.first_of_text ? ROW_W'(item.origin_y) : row_reg;
        halt_e = item.first_of_text ? 1'b0 : halt_reg;
        row_nl = down(row_e);
        col_sum = {1'b0, col_e} + (COL_W+1)'(GLYPH_SIZE);
        if (col_sum > (COL_W+1)'(FRAME_WIDTH))
        begin
            col_1 = ls_e;
            row_1 = row_nl;
        end
        else
        begin
            col_1 = col_e;
            row_1 = row_e;
        end
        row_1_sum = {1'b0, row_1} + (ROW_W+1)'(GLYPH_SIZE);
        printable = (item.char_code >= FIRST_CODE) && (item.char_code <= LAST_FONT);

        col_next  = col_reg;
        row_next  = row_reg;
        ls_next   = ls_reg;
        halt_next = halt_reg;
        cmd.kind    = CMD_NONE;
        cmd.stopped = 1'b0;
        cmd.gidx    = GIDX_W'(item.char_code - FIRST_CODE);
        cmd.col     = col_1;
        cmd.row     = row_1;
        cmd.addr    = item.read_address;

        case (item.operation)
            OP_CLEAR: cmd.kind = CMD_CLEAR;
            OP_READ:  cmd.kind = CMD_READ;
            OP_DRAW:
            begin
                ls_next   = ls_e;
                halt_next = halt_e;
                col_next  = col_e;
                row_next  = row_e;
                if (halt_e)
                    cmd.stopped = 1'b1;
                else if (item.char_code == NEWLINE_CODE)
                begin
                    col_next = ls_e;
                    row_next = row_nl;
                end
                else
                begin
                    col_next = col_1;
                    row_next = row_1;
                    if (row_1_sum > (ROW_W+1)'(FRAME_HEIGHT))
                    begin
                        halt_next   = 1'b1;
                        cmd.stopped = 1'b1;
                    end
                    else
                    begin
                        col_next = col_1 + COL_W'(GLYPH_SIZE);
                        if (printable)
                            cmd.kind = CMD_DRAW;
                    end
                end
            end
            default: cmd.kind = CMD_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            ls_reg   <= '0;
            halt_reg <= 1'b0;
        end
        else if (accept)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            ls_reg   <= ls_next;
            halt_reg <= halt_next;
        end
    end

endmodule

// ===== hw/rtl/tgfw_queue.sv =====
// two-entry command queue between front and back
module tgfw_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  tgfw_pkg::cmd_t       din,
    input  logic                 pop,
    output tgfw_pkg::cmd_t       dout,
    output tgfw_pkg::q_status_t  status
);
    import tgfw_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign dout         = entry_reg[rd_ptr_reg];
    assign status.empty = (count_reg == 2'd0);
    assign status.full  = (count_reg == 2'd2);

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ===== hw/rtl/tgfw_back.sv =====
// back end: frame store, clearing sweep, glyph read-modify-write, byte reads
module tgfw_back #(
    parameter int FRAME_WIDTH  = 128,
    parameter int FRAME_HEIGHT = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  tgfw_pkg::cmd_t    cmd,
    output logic              pop,
    output logic              init,
    output logic              done,
    output tgfw_pkg::result_t result
);
    import tgfw_pkg::*;

    localparam int PAGES = (FRAME_HEIGHT + 7) / 8;
    localparam int DEPTH = FRAME_WIDTH * PAGES;
    localparam int AW    = $clog2(DEPTH);
    localparam int PG_W  = ROW_W - 2;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CLEAR = 6'b000010,
        S_DRAW  = 6'b000100,
        S_FIN   = 6'b001000,
        S_READ  = 6'b010000,
        S_RDONE = 6'b100000
    } state_t;

    state_t           state_reg, state_next;
    logic             init_reg, init_next;
    logic [AW-1:0]    cnt_reg, cnt_next;
    logic [3:0]       step_reg, step_next;
    cmd_t             cur_reg;
    logic [7:0]       glyph_reg [8];
    logic             done_reg, done_next;
    result_t          res_reg, res_next;

    logic [7:0]       mem [DEPTH];
    logic [7:0]       rdata_reg;
    logic             re, we;
    logic [AW-1:0]    raddr, waddr;
    logic [7:0]       wdata;

    logic             wr_pend_reg, wr_pend_next;
    logic [AW-1:0]    wr_addr_reg;
    logic [7:0]       wr_bits_reg;

    // per-step geometry
    logic [2:0]       c;
    logic [COL_W:0]   x;
    logic [PG_W-1:0]  page;
    logic [7:0]       v, bits, ymask;
    logic [15:0]      shifted;
    logic [ROW_W:0]   y;
    logic [15:0]      step_addr;
    logic             step_valid;
    logic [15:0]      rd_ext;
    logic             rd_in_range;

    assign pop    = (state_reg == S_IDLE) && !q_empty;
    assign init   = init_reg;
    assign done   = done_reg;
    assign result = res_reg;

    always_comb
    begin
        c = step_reg[3:1];
        x = {1'b0, cur_reg.col} + (COL_W+1)'(c);
        page = PG_W'(cur_reg.row[ROW_W-1:3]) + PG_W'(step_reg[0]);
        for (int r = 0; r < 8; r++)
            v[r] = glyph_reg[r][c];
        shifted = {8'b0, v} << cur_reg.row[2:0];
        bits = step_reg[0] ? shifted[15:8] : shifted[7:0];
        for (int b = 0; b < 8; b++)
        begin
            y = {page, 3'(b)};
            ymask[b] = (y < (ROW_W+1)'(FRAME_HEIGHT));
        end
        bits = bits & ymask;
        step_addr = 16'(x) + 16'(page) * 16'(FRAME_WIDTH);
        step_valid = (x < (COL_W+1)'(FRAME_WIDTH)) && (bits != 8'd0);
        rd_ext = 16'(cur_reg.addr);
        rd_in_range = (rd_ext < 16'(DEPTH));
    end

    always_comb
    begin
        state_next   = state_reg;
        init_next    = init_reg;
        cnt_next     = cnt_reg;
        step_next    = step_reg;
        done_next    = 1'b0;
        res_next     = '0;
        wr_pend_next = 1'b0;
        re    = 1'b0;
        raddr = step_addr[AW-1:0];
        we    = 1'b0;
        waddr = wr_addr_reg;
        wdata = rdata_reg | wr_bits_reg;

        // finishing write of the previous draw step
        if (wr_pend_reg)
            we = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    unique case (cmd.kind)
                        CMD_CLEAR:
                        begin
                            cnt_next   = '0;
                            state_next = S_CLEAR;
                        end
                        CMD_DRAW:
                        begin
                            step_next  = '0;
                            state_next = S_DRAW;
                        end
                        CMD_READ: state_next = S_READ;
                        default:
                        begin
                            done_next = 1'b1;
                            res_next.text_stopped = cmd.stopped;
                        end
                    endcase
                end
            end
            S_CLEAR:
            begin
                we    = 1'b1;
                waddr = cnt_reg;
                wdata = 8'd0;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                    init_next  = 1'b0;
                    done_next  = !init_reg;
                end
            end
            S_DRAW:
            begin
                re = step_valid;
                wr_pend_next = step_valid;
                step_next = step_reg + 1'b1;
                if (step_reg == 4'd15)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_READ:
            begin
                re    = 1'b1;
                raddr = rd_ext[AW-1:0];
                state_next = S_RDONE;
            end
            S_RDONE:
            begin
                done_next = 1'b1;
                res_next.read_data = rd_in_range ? rdata_reg : 8'd0;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        res_reg     <= res_next;
        wr_addr_reg <= step_addr[AW-1:0];
        wr_bits_reg <= bits;
        if (pop)
        begin
            cur_reg <= cmd;
            // only font glyphs carry a valid table index
            if (cmd.kind == CMD_DRAW)
            begin
                for (int r = 0; r < 8; r++)
                    glyph_reg[r] <= FONT_ROM[cmd.gidx][r];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            init_reg    <= 1'b1;
            cnt_reg     <= '0;
            step_reg    <= '0;
            done_reg    <= 1'b0;
            wr_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            init_reg    <= init_next;
            cnt_reg     <= cnt_next;
            step_reg    <= step_next;
            done_reg    <= done_next;
            wr_pend_reg <= wr_pend_next;
        end
    end

endmodule

// ===== hw/rtl/tgfw_checker.sv =====
// port-level checker for the text glyph framebuffer writer, with its bind
module tgfw_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input tgfw_pkg::result_t result
);
    import tgfw_pkg::*;

    logic [2:0] outstanding_reg;
    logic       xfer;

    assign xfer = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            outstanding_reg <= '0;
        else
            outstanding_reg <= outstanding_reg + {2'b0, xfer} - {2'b0, done};
    end

    // no result without an item still owed one
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> outstanding_reg != 3'd0)
        else $error("result without pending item");

    // queue, back end and result register bound the items in flight
    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg <= 3'd4)
        else $error("too many items in flight");

    // a dropped character never carries frame data
    a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.text_stopped) |-> result.read_data == 8'd0)
        else $error("stopped result with data");

    // a result never follows its transfer at once: the queue entry and the done register lie between
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (xfer && outstanding_reg == 3'd0) |=> !done)
        else $error("result too early");

endmodule

bind text_glyph_framebuffer_writer_core tgfw_checker u_tgfw_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

// ===== sim/text_glyph_framebuffer_writer_core_test.sv =====
// testbench for the text glyph framebuffer writer: directed and random draw, clear and read
`timescale 1ns / 1ps

module text_glyph_framebuffer_writer_core_test;
    import tgfw_pkg::*;

    localparam int FW = 128;
    localparam int FH = 64;
    localparam int PAGES = (FH + 7) / 8;
    localparam int DEPTH = FW * PAGES;
    localparam int RANDOM_ITEMS = 1200;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    item_t   item;
    logic    done;
    result_t result;

    text_glyph_framebuffer_writer_core #(.FRAME_WIDTH(FW), .FRAME_HEIGHT(FH)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .item(item), .done(done), .result(result)
    );

    // shadow of the frame and the text cursor
    logic [7:0]       shadow_frame [DEPTH];
    logic [COL_W-1:0] shadow_col;
    logic [ROW_W-1:0] shadow_row;
    logic [COL_W-1:0] shadow_line_col;
    logic             shadow_halted;
    result_t          pending_results [$];
    int               errors;

    // font rows for one character code, zero where there is no glyph
    function automatic logic [7:0] glyph_bits(input logic [7:0] code, input int r);
        if (code >= FIRST_CODE && code <= LAST_FONT)
            return FONT_ROM[code - FIRST_CODE][r];
        return 8'h00;
    endfunction

    function automatic void advance_line();
        shadow_col = shadow_line_col;
        shadow_row = shadow_row + ROW_W'(GLYPH_SIZE);
        if (shadow_row > FH)
            shadow_row = ROW_W'(FH);
    endfunction

    // returns the stopped flag of one draw
    function automatic logic render_char(input item_t it);
        int x, y;
        logic [7:0] bits;
        if (it.first_of_text)
        begin
            shadow_col = COL_W'(it.origin_x);
            shadow_row = ROW_W'(it.origin_y);
            shadow_line_col = COL_W'(it.origin_x);
            shadow_halted = 1'b0;
        end
        if (shadow_halted)
            return 1'b1;
        if (it.char_code == NEWLINE_CODE)
        begin
            advance_line();
            return 1'b0;
        end
        if (shadow_col + GLYPH_SIZE > FW)
            advance_line();
        if (shadow_row + GLYPH_SIZE > FH)
        begin
            shadow_halted = 1'b1;
            return 1'b1;
        end
        for (int r = 0; r < 8; r++)
        begin
            bits = glyph_bits(it.char_code, r);
            for (int c = 0; c < 8; c++)
            begin
                x = shadow_col + c;
                y = shadow_row + r;
                if (bits[c] && x < FW && y < FH)
                    shadow_frame[x + (y / 8) * FW][y % 8] = 1'b1;
            end
        end
        shadow_col = shadow_col + COL_W'(GLYPH_SIZE);
        return 1'b0;
    endfunction

    function automatic result_t predict_result(input item_t it);
        result_t res;
        res = '0;
        if (it.operation == OP_CLEAR)
        begin
            for (int i = 0; i < DEPTH; i++)
                shadow_frame[i] = 8'h00;
        end
        else if (it.operation == OP_DRAW)
            res.text_stopped = render_char(it);
        else if (it.operation == OP_READ && it.read_address < DEPTH)
            res.read_data = shadow_frame[it.read_address];
        return res;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #100ms;
        $display("timeout at %0t", $time);
        $display("Test completed with failures");
        $finish;
    end

    // result checker, results cannot be held off
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected result: expected none actual %h", $time, result);
                errors++;
            end
            else
            begin
                result_t exp_res;
                exp_res = pending_results.pop_front();
                if (result.read_data !== exp_res.read_data)
                begin
                    $display("%0t read_data: expected %h actual %h",
                             $time, exp_res.read_data, result.read_data);
                    errors++;
                end
                if (result.text_stopped !== exp_res.text_stopped)
                begin
                    $display("%0t text_stopped: expected %b actual %b",
                             $time, exp_res.text_stopped, result.text_stopped);
                    errors++;
                end
            end
        end
    end

    int burst_left;

    // one transfer; sender sends in bursts with random idle gaps
    task automatic send_item(input item_t it);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0)
                gap = $urandom_range(0, 20);
        end
        burst_left--;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(predict_result(it));
    endtask

    function automatic item_t make_item(input logic [1:0] op, input logic [7:0] code,
                                        input logic first, input logic [6:0] ox,
                                        input logic [5:0] oy, input logic [9:0] addr);
        item_t it;
        it.operation = op;
        it.char_code = code;
        it.first_of_text = first;
        it.origin_x = ox;
        it.origin_y = oy;
        it.read_address = addr;
        return it;
    endfunction

    function automatic item_t random_noise();
        item_t it;
        it = item_t'($bits(item_t)'({$urandom, $urandom}));
        return it;
    endfunction

    task automatic test_directed();
        send_item(make_item(OP_DRAW, "A", 1, 0, 0, 0));
        send_item(make_item(OP_READ, 0, 0, 0, 0, 0));
        send_item(make_item(OP_READ, 0, 0, 0, 0, 1));
        send_item(make_item(OP_DRAW, "Z", 0, 0, 0, 0));
        send_item(make_item(OP_DRAW, 8'd127, 0, 0, 0, 0));   // blank glyph past the font
        send_item(make_item(OP_DRAW, 8'd255, 0, 0, 0, 0));   // outside printable range
        send_item(make_item(OP_DRAW, NEWLINE_CODE, 0, 0, 0, 0));
        send_item(make_item(OP_DRAW, "#", 0, 0, 0, 0));
        send_item(make_item(OP_READ, 0, 0, 0, 0, 10'd128));
        // glyphs that would pass the right edge wrap to the next line, then halt at the bottom edge
        send_item(make_item(OP_DRAW, "*", 1, 7'd127, 6'd63, 0));
        send_item(make_item(OP_DRAW, "*", 0, 0, 0, 0));
        send_item(make_item(OP_DRAW, "W", 1, 7'd121, 6'd50, 0));
        send_item(make_item(OP_DRAW, "W", 0, 0, 0, 0));
        send_item(make_item(OP_READ, 0, 0, 0, 0, 10'd1023));
        send_item(make_item(OP_READ, 0, 0, 0, 0, 10'd889));
        send_item(make_item(OP_DRAW, "Q", 1, 7'd60, 6'd57, 0));  // halted at once
        send_item(make_item(OP_DRAW, "Q", 0, 0, 0, 0));
        send_item(make_item(OP_NOP, 8'hFF, 1, 7'h7F, 6'h3F, 10'h3FF));
        send_item(make_item(OP_CLEAR, 0, 0, 0, 0, 0));
        send_item(make_item(OP_READ, 0, 0, 0, 0, 0));
    endtask

    // text strings with random content, reads at random addresses, few clears
    task automatic test_random_text();
        int sent;
        int len;
        item_t it;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                it = random_noise();
                if (it.operation == OP_CLEAR && $urandom_range(0, 3) != 0)
                    it.operation = OP_READ;
                send_item(it);
                sent++;
            end
            else if ($urandom_range(0, 29) == 0)
            begin
                send_item(make_item(OP_CLEAR, 0, 0, 0, 0, 0));
                sent++;
            end
            else
            begin
                len = $urandom_range(1, 24);
                for (int i = 0; i < len; i++)
                begin
                    it = random_noise();
                    it.operation = OP_DRAW;
                    it.first_of_text = (i == 0);
                    case ($urandom_range(0, 9))
                        0: it.char_code = NEWLINE_CODE;
                        1: ;
                        default: it.char_code = 8'($urandom_range(32, 90));
                    endcase
                    send_item(it);
                end
                repeat ($urandom_range(1, 6))
                begin
                    it = make_item(OP_READ, 0, 0, 0, 0, 10'($urandom_range(0, 1023)));
                    send_item(it);
                end
                sent += len;
            end
        end
    endtask

    initial
    begin
        errors = 0;
        burst_left = 0;
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        for (int i = 0; i < DEPTH; i++)
            shadow_frame[i] = 8'h00;
        shadow_col = '0;
        shadow_row = '0;
        shadow_line_col = '0;
        shadow_halted = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_text();
        start <= 1'b0;
        // drain: wait for every pending result, with a bound on the wait
        fork
            begin
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
            begin
                repeat (200000) @(posedge clk);
            end
        join_any
        disable fork;
        if (pending_results.size() != 0)
        begin
            $display("%0t results missing: %0d", $time, pending_results.size());
            errors++;
        end
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

// ===== files.f =====
hw/rtl/tgfw_pkg.sv
hw/rtl/tgfw_front.sv
hw/rtl/tgfw_queue.sv
hw/rtl/tgfw_back.sv
hw/rtl/text_glyph_framebuffer_writer_core.sv
hw/rtl/tgfw_checker.sv
sim/text_glyph_framebuffer_writer_core_test.sv
